FILE: sv/mqtf_pkg.sv
// Shared types, character codes and the per-symbol match step for the topic filter matcher.
package mqtf_pkg;

	// Default filter store depth in bytes
	localparam int FILTER_DEPTH_DEF = 64;

	// Filter bytes held in one record: the byte before a position, the byte at it and four after it
	localparam int WIN = 6;

	// Mode transitions one symbol can pass through before it settles
	localparam int RUN_STEPS = 5;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_DOLLAR = 8'h24;

	// Input beat: filter byte (func = 0) or topic byte (func = 1)
	typedef struct packed {
		logic       func;
		logic [7:0] char_byte;
		logic       last;
	} in_item_t;

	// Result beat
	typedef struct packed {
		logic matched;
		logic status;
	} out_item_t;

	// Matcher modes
	typedef enum logic [5:0] {
		M_START     = 6'b000001,
		M_WALK      = 6'b000010,
		M_PLUS_SKIP = 6'b000100,
		M_HASH_SKIP = 6'b001000,
		M_TAIL      = 6'b010000,
		M_DONE      = 6'b100000
	} mode_t;

	// One filter symbol: a byte, or the end of the filter
	typedef struct packed {
		logic       is_end;
		logic [7:0] ch;
	} sym_t;

	// Filter symbols at positions p-1 .. p+4
	typedef sym_t [WIN-1:0] win_t;

	// Memory record: filter bytes j-1 .. j+4 for position j
	typedef logic [WIN-1:0][7:0] rec_t;

	// Matcher state as it moves through one symbol; rel is the offset from the window base
	typedef struct packed {
		mode_t     mode;
		logic [1:0] rel;
		out_item_t verdict;
	} step_t;

	function automatic logic is_ch(sym_t s, logic [7:0] c);
		return !s.is_end && (s.ch == c);
	endfunction

	function automatic sym_t win_at(win_t w, logic [2:0] idx);
		sym_t r;
		r.is_end = 1'b1;
		r.ch     = 8'h00;
		if (idx < 3'(WIN)) begin
			r = w[idx];
		end
		return r;
	endfunction

	function automatic step_t finish(step_t s, logic m, logic st);
		step_t r;
		r                 = s;
		r.mode            = M_DONE;
		r.verdict.matched = m;
		r.verdict.status  = st;
		return r;
	endfunction

	// Consume one topic symbol (a byte, or the end of the topic).
	// nend: the next symbol is the end. p_zero: the window base is position zero.
	// bad_ge[r]: a hash with a byte after it sits at or beyond base + r.
	function automatic step_t run_sym(step_t st, win_t w, sym_t tc, logic nend,
			logic p_zero, logic ovf, logic [3:0] bad_ge);
		step_t s;
		logic  go;
		logic  tc_wild;
		logic  pgt0;
		sym_t  sm1;
		sym_t  s0;
		sym_t  s1;
		sym_t  s2;
		sym_t  s3;
		s       = st;
		go      = 1'b1;
		tc_wild = is_ch(tc, CH_PLUS) || is_ch(tc, CH_HASH);
		for (int i = 0; i < RUN_STEPS; i++) begin
			sm1  = win_at(w, {1'b0, s.rel});
			s0   = win_at(w, {1'b0, s.rel} + 3'd1);
			s1   = win_at(w, {1'b0, s.rel} + 3'd2);
			s2   = win_at(w, {1'b0, s.rel} + 3'd3);
			s3   = win_at(w, {1'b0, s.rel} + 3'd4);
			pgt0 = !p_zero || (s.rel != 2'd0);
			if (go) begin
				unique case (s.mode)
					M_START: begin
						// empty or overflowed filter, then the leading dollar rule
						if (w[1].is_end || ovf) begin
							s  = finish(s, 1'b0, 1'b1);
							go = 1'b0;
						end else if (is_ch(w[1], CH_DOLLAR) != is_ch(tc, CH_DOLLAR)) begin
							s  = finish(s, 1'b0, 1'b0);
							go = 1'b0;
						end else begin
							s.rel  = 2'd0;
							s.mode = M_WALK;
						end
					end
					M_WALK: begin
						if (s0.is_end) begin
							s.mode = M_TAIL;
						end else if (tc_wild) begin
							s  = finish(s, 1'b0, 1'b1);
							go = 1'b0;
						end else if ((s0 != tc) || tc.is_end) begin
							go = 1'b0;
							if (is_ch(s0, CH_PLUS)) begin
								if (pgt0 && !is_ch(sm1, CH_SLASH)) begin
									s = finish(s, 1'b0, 1'b1);
								end else if (!s1.is_end && !is_ch(s1, CH_SLASH)) begin
									s = finish(s, 1'b0, 1'b1);
								end else begin
									s.rel  = s.rel + 2'd1;
									s.mode = M_PLUS_SKIP;
									go     = 1'b1;
								end
							end else if (is_ch(s0, CH_HASH)) begin
								if (pgt0 && !is_ch(sm1, CH_SLASH)) begin
									s = finish(s, 1'b0, 1'b1);
								end else if (!s1.is_end) begin
									s = finish(s, 1'b0, 1'b1);
								end else begin
									s.mode = M_HASH_SKIP;
									go     = 1'b1;
								end
							end else if (tc.is_end && pgt0 && is_ch(sm1, CH_PLUS) &&
									is_ch(s0, CH_SLASH) && is_ch(s1, CH_HASH)) begin
								// topic ends where a plus level is followed by a hash level
								s = finish(s, 1'b1, 1'b0);
							end else if (bad_ge[s.rel]) begin
								s = finish(s, 1'b0, 1'b1);
							end else begin
								s = finish(s, 1'b0, 1'b0);
							end
						end else begin
							go = 1'b0;
							if (nend && is_ch(s1, CH_SLASH) && is_ch(s2, CH_HASH) &&
									s3.is_end) begin
								// last topic byte against a trailing hash level
								s = finish(s, 1'b1, 1'b0);
							end else begin
								s.rel = s.rel + 2'd1;
								if (nend) begin
									if (s1.is_end) begin
										s = finish(s, 1'b1, 1'b0);
									end else if (is_ch(s1, CH_PLUS) && s2.is_end) begin
										if (!is_ch(s0, CH_SLASH)) begin
											s = finish(s, 1'b0, 1'b1);
										end else begin
											s = finish(s, 1'b1, 1'b0);
										end
									end
								end
							end
						end
					end
					M_PLUS_SKIP: begin
						if (!tc.is_end && !is_ch(tc, CH_SLASH)) begin
							if (tc_wild) begin
								s = finish(s, 1'b0, 1'b1);
							end
							go = 1'b0;
						end else if (tc.is_end && s0.is_end) begin
							s  = finish(s, 1'b1, 1'b0);
							go = 1'b0;
						end else begin
							s.mode = M_WALK;
						end
					end
					M_HASH_SKIP: begin
						if (tc.is_end) begin
							s = finish(s, 1'b1, 1'b0);
						end else if (tc_wild) begin
							s = finish(s, 1'b0, 1'b1);
						end
						go = 1'b0;
					end
					M_TAIL: begin
						if (tc.is_end) begin
							s = finish(s, 1'b0, 1'b0);
						end else if (tc_wild) begin
							s = finish(s, 1'b0, 1'b1);
						end
						go = 1'b0;
					end
					default: begin
						go = 1'b0;
					end
				endcase
			end
		end
		return s;
	endfunction

endpackage

FILE: sv/mqtt_topic_filter_match_top.sv
// Top level of the topic filter matcher: filter record memory, match stage and verdict stage.
//
// The block takes one byte per clock on the item channel, filter bytes and topic bytes
// alike, and gives one verdict per topic on the result channel. The state after a topic's
// last byte is registered in the verdict stage, and the verdict then moves to the result
// register and waits there while the next topic streams in. Filter bytes are written
// into a record memory of FILTER_DEPTH entries as they arrive; each topic byte costs one
// read of that memory, at the filter position that the previous byte produced in the
// same cycle, and that single read per byte sets the rate of one byte per clock. Bytes
// near the end of the filter come from a small tail register instead. The memory needs
// no clearing after reset. A stall on the result channel holds back the next verdict and,
// once the verdict stage is also full, the item channel.
module mqtt_topic_filter_match_top #(
	parameter int FILTER_DEPTH = mqtf_pkg::FILTER_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  mqtf_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_stall,
	output mqtf_pkg::out_item_t result
);

	localparam int LW   = $clog2(FILTER_DEPTH + 1);
	localparam int AW   = $clog2(FILTER_DEPTH);
	localparam int TAIL = mqtf_pkg::WIN - 1;

	// filter bookkeeping
	logic [LW-1:0] len_q;
	logic          ovf_q;
	logic          complete_q;
	logic          bad_valid_q;
	logic [LW-1:0] bad_pos_q;
	logic [7:0]    tail_q [TAIL];

	// match state
	mqtf_pkg::mode_t     mode_q;
	logic [LW-1:0]       p_q;
	mqtf_pkg::out_item_t verdict_q;

	// record memory and read path
	mqtf_pkg::rec_t rec_mem_q [FILTER_DEPTH];
	mqtf_pkg::rec_t rec_q;
	mqtf_pkg::rec_t fwd_q;
	logic           fwd_hit_q;

	// verdict stage
	logic            valid_s1;
	mqtf_pkg::step_t st_s1;
	mqtf_pkg::win_t  win_s1;
	logic            pz_s1;
	logic [3:0]      bad_ge_s1;

	// result register
	logic                res_valid_q;
	mqtf_pkg::out_item_t res_q;

	logic            acc;
	logic            flt_acc;
	logic            top_acc;
	logic            top_last;
	logic            adv_s1;
	logic [LW-1:0]   len_eff;
	logic            store;
	logic            we;
	logic [LW-1:0]   wpos;
	logic [AW-1:0]   waddr;
	mqtf_pkg::rec_t  wdata;
	mqtf_pkg::rec_t  rec_cur;
	logic            mem_mode;
	logic [LW-1:0]   diff;
	logic [2:0]      d3;
	logic [2:0]      tidx;
	mqtf_pkg::win_t  win_cur;
	logic [3:0]      bad_ge;
	mqtf_pkg::step_t st_in;
	mqtf_pkg::step_t run1;
	mqtf_pkg::step_t run2;
	mqtf_pkg::sym_t  tc_in;
	mqtf_pkg::sym_t  tc_end;
	logic [LW-1:0]   p_next;

	// handshake: the verdict stage frees when the result register can take its beat
	assign adv_s1       = !res_valid_q || !result_stall;
	assign item_stall   = valid_s1 && !adv_s1;
	assign acc          = item_valid && !item_stall;
	assign flt_acc      = acc && !item.func;
	assign top_acc      = acc && item.func;
	assign top_last     = top_acc && item.last;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// filter write: a new filter restarts at length zero
	assign len_eff = complete_q ? '0 : len_q;
	assign store   = len_eff < LW'(FILTER_DEPTH);
	assign we      = flt_acc && store && (len_eff >= LW'(4));
	assign wpos    = len_eff - LW'(4);
	assign waddr   = wpos[AW-1:0];

	// record for position len-4: the five stored bytes before the new byte, and the new byte
	always_comb begin
		for (int k = 0; k < TAIL; k++) begin
			wdata[k] = tail_q[TAIL-1-k];
		end
		wdata[TAIL] = item.char_byte;
	end

	// window: memory record while four bytes follow p, else the tail register
	assign rec_cur  = fwd_hit_q ? fwd_q : rec_q;
	assign mem_mode = ({1'b0, p_q} + (LW+1)'(4)) < {1'b0, len_q};
	assign diff     = len_q - p_q;
	assign d3       = diff[2:0];

	always_comb begin
		tidx = '0;
		for (int k = 0; k < mqtf_pkg::WIN; k++) begin
			tidx = d3 - 3'(k);
			if (mem_mode) begin
				win_cur[k].is_end = 1'b0;
				win_cur[k].ch     = rec_cur[k];
			end else if ((d3 >= 3'(k)) && (tidx < 3'(TAIL))) begin
				win_cur[k].is_end = 1'b0;
				win_cur[k].ch     = tail_q[tidx];
			end else begin
				win_cur[k].is_end = 1'b1;
				win_cur[k].ch     = 8'h00;
			end
		end
	end

	// hash with a byte after it at or beyond each reachable position
	always_comb begin
		for (int r = 0; r < 4; r++) begin
			bad_ge[r] = bad_valid_q && ({1'b0, bad_pos_q} >= ({1'b0, p_q} + (LW+1)'(r)));
		end
	end

	// match the topic byte against the window
	always_comb begin
		st_in.mode    = mode_q;
		st_in.rel     = 2'd0;
		st_in.verdict = verdict_q;
		tc_in.is_end  = 1'b0;
		tc_in.ch      = item.char_byte;
		tc_end.is_end = 1'b1;
		tc_end.ch     = 8'h00;
		run1 = mqtf_pkg::run_sym(st_in, win_cur, tc_in, item.last, p_q == '0, ovf_q, bad_ge);
		run2 = mqtf_pkg::run_sym(st_s1, win_s1, tc_end, 1'b0, pz_s1, 1'b0, bad_ge_s1);
	end

	// next filter position also addresses the memory read
	always_comb begin
		p_next = p_q;
		if (flt_acc || top_last) begin
			p_next = '0;
		end else if (top_acc) begin
			p_next = p_q + LW'(run1.rel);
		end
	end

	// record memory: one write port, one registered read
	always_ff @(posedge clk) begin
		if (we) begin
			rec_mem_q[waddr] <= wdata;
		end
		rec_q <= rec_mem_q[p_next[AW-1:0]];
		fwd_q <= wdata;
	end

	// forward a write that lands on the address read in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= we && (waddr == p_next[AW-1:0]);
		end
	end

	// filter length, overflow and hash tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			ovf_q       <= 1'b0;
			complete_q  <= 1'b0;
			bad_valid_q <= 1'b0;
		end else if (flt_acc) begin
			complete_q <= item.last;
			if (store) begin
				len_q <= len_eff + LW'(1);
				ovf_q <= complete_q ? 1'b0 : ovf_q;
			end else begin
				len_q <= len_eff;
				ovf_q <= 1'b1;
			end
			if (store && (len_eff != '0) && (tail_q[0] == mqtf_pkg::CH_HASH)) begin
				bad_valid_q <= 1'b1;
			end else if (complete_q) begin
				bad_valid_q <= 1'b0;
			end
		end
	end

	// shift stored bytes into the tail and note the latest hash with a successor
	always_ff @(posedge clk) begin
		if (flt_acc && store) begin
			tail_q[0] <= item.char_byte;
			for (int i = 1; i < TAIL; i++) begin
				tail_q[i] <= tail_q[i-1];
			end
			if ((len_eff != '0) && (tail_q[0] == mqtf_pkg::CH_HASH)) begin
				bad_pos_q <= len_eff - LW'(1);
			end
		end
	end

	// match state: restart on filter bytes and after each topic
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= mqtf_pkg::M_START;
			p_q       <= '0;
			verdict_q <= '0;
		end else if (flt_acc || top_last) begin
			mode_q    <= mqtf_pkg::M_START;
			p_q       <= '0;
			verdict_q <= '0;
		end else if (top_acc) begin
			mode_q    <= run1.mode;
			p_q       <= p_next;
			verdict_q <= run1.verdict;
		end
	end

	// verdict stage: hold the state after the last topic byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (top_last) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (top_last) begin
			st_s1     <= run1;
			win_s1    <= win_cur;
			pz_s1     <= (p_q == '0);
			bad_ge_s1 <= bad_ge;
		end
	end

	// result register: apply the end of topic and present the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			res_q <= run2.verdict;
		end
	end

endmodule

FILE: dv/tb_mqtt_topic_filter_match_top.sv
// Testbench for the topic filter matcher: random filters and topics against a verdict predictor.
module tb_mqtt_topic_filter_match_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH       = mqtf_pkg::FILTER_DEPTH_DEF;
	localparam int N_BEATS     = 1350;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN       = 20;

	// Filter symbol past the end of the loaded bytes
	localparam logic [8:0] SYM_END  = 9'h100;
	localparam logic [8:0] S_PLUS   = {1'b0, mqtf_pkg::CH_PLUS};
	localparam logic [8:0] S_HASH   = {1'b0, mqtf_pkg::CH_HASH};
	localparam logic [8:0] S_SLASH  = {1'b0, mqtf_pkg::CH_SLASH};
	localparam logic [8:0] S_DOLLAR = {1'b0, mqtf_pkg::CH_DOLLAR};

	// Tracks the loaded filter and the topic walk, and holds the verdicts still to arrive
	class verdict_board;
		logic [7:0]          pattern [DEPTH];
		int                  pat_len;
		int                  pat_pos;
		mqtf_pkg::mode_t     mode;
		logic                v_match;
		logic                v_status;
		bit                  pat_done;
		bit                  pat_ovf;
		mqtf_pkg::out_item_t verdicts_due[$];
		int                  errors;

		function new();
			pat_len  = 0;
			pat_pos  = 0;
			mode     = mqtf_pkg::M_START;
			v_match  = 1'b0;
			v_status = 1'b0;
			pat_done = 1'b0;
			pat_ovf  = 1'b0;
			errors   = 0;
		endfunction

		function logic [8:0] filter_sym(int k);
			if (k >= 0 && k < pat_len && k < DEPTH) begin
				return {1'b0, pattern[k]};
			end
			return SYM_END;
		endfunction

		function void settle(logic m, logic st);
			v_match  = m;
			v_status = st;
			mode     = mqtf_pkg::M_DONE;
		endfunction

		// Advance the walk by one topic symbol; nend says the following symbol is the end
		function void match_symbol(logic [8:0] tc, bit nend);
			int         p;
			logic [8:0] s0;
			logic [8:0] nx;
			bit         wild;
			wild = (tc == S_PLUS) || (tc == S_HASH);
			while (1'b1) begin
				p = pat_pos;
				case (mode)
					mqtf_pkg::M_START: begin
						if (pat_len == 0 || pat_ovf) begin
							settle(1'b0, 1'b1);
							return;
						end
						if ((filter_sym(0) == S_DOLLAR) != (tc == S_DOLLAR)) begin
							settle(1'b0, 1'b0);
							return;
						end
						pat_pos = 0;
						mode    = mqtf_pkg::M_WALK;
					end
					mqtf_pkg::M_WALK: begin
						if (p >= pat_len) begin
							mode = mqtf_pkg::M_TAIL;
						end else if (wild) begin
							settle(1'b0, 1'b1);
							return;
						end else begin
							s0 = filter_sym(p);
							if (s0 != tc || tc == SYM_END) begin
								if (s0 == S_PLUS) begin
									nx = filter_sym(p + 1);
									if (p > 0 && filter_sym(p - 1) != S_SLASH) begin
										settle(1'b0, 1'b1);
										return;
									end
									if (nx != SYM_END && nx != S_SLASH) begin
										settle(1'b0, 1'b1);
										return;
									end
									pat_pos = p + 1;
									mode    = mqtf_pkg::M_PLUS_SKIP;
								end else if (s0 == S_HASH) begin
									if (p > 0 && filter_sym(p - 1) != S_SLASH) begin
										settle(1'b0, 1'b1);
										return;
									end
									if (filter_sym(p + 1) != SYM_END) begin
										settle(1'b0, 1'b1);
										return;
									end
									mode = mqtf_pkg::M_HASH_SKIP;
								end else begin
									// topic ends where a plus level meets a hash level
									if (tc == SYM_END && p > 0 && filter_sym(p - 1) == S_PLUS &&
											s0 == S_SLASH && filter_sym(p + 1) == S_HASH) begin
										settle(1'b1, 1'b0);
										return;
									end
									// a misplaced hash further on makes the mismatch invalid
									for (int k = p; k < pat_len; k++) begin
										if (filter_sym(k) == S_HASH && filter_sym(k + 1) != SYM_END) begin
											settle(1'b0, 1'b1);
											return;
										end
									end
									settle(1'b0, 1'b0);
									return;
								end
							end else begin
								if (nend && filter_sym(p + 1) == S_SLASH &&
										filter_sym(p + 2) == S_HASH && filter_sym(p + 3) == SYM_END) begin
									settle(1'b1, 1'b0);
									return;
								end
								p       = p + 1;
								pat_pos = p;
								if (nend) begin
									if (filter_sym(p) == SYM_END) begin
										settle(1'b1, 1'b0);
									end else if (filter_sym(p) == S_PLUS &&
											filter_sym(p + 1) == SYM_END) begin
										if (filter_sym(p - 1) != S_SLASH) begin
											settle(1'b0, 1'b1);
										end else begin
											settle(1'b1, 1'b0);
										end
									end
								end
								return;
							end
						end
					end
					mqtf_pkg::M_PLUS_SKIP: begin
						if (tc != SYM_END && tc != S_SLASH) begin
							if (wild) begin
								settle(1'b0, 1'b1);
							end
							return;
						end
						if (tc == SYM_END && filter_sym(p) == SYM_END) begin
							settle(1'b1, 1'b0);
							return;
						end
						mode = mqtf_pkg::M_WALK;
					end
					mqtf_pkg::M_HASH_SKIP: begin
						if (tc == SYM_END) begin
							settle(1'b1, 1'b0);
						end else if (wild) begin
							settle(1'b0, 1'b1);
						end
						return;
					end
					mqtf_pkg::M_TAIL: begin
						if (tc == SYM_END) begin
							settle(1'b0, 1'b0);
						end else if (wild) begin
							settle(1'b0, 1'b1);
						end
						return;
					end
					default: begin
						return;
					end
				endcase
			end
		endfunction

		function void clear_walk();
			mode     = mqtf_pkg::M_START;
			pat_pos  = 0;
			v_match  = 1'b0;
			v_status = 1'b0;
		endfunction

		// Update the filter or the walk with an accepted input beat
		function void note_item(mqtf_pkg::in_item_t b);
			mqtf_pkg::out_item_t v;
			if (!b.func) begin
				if (pat_done) begin
					pat_len  = 0;
					pat_ovf  = 1'b0;
					pat_done = 1'b0;
				end
				if (pat_len < DEPTH) begin
					pattern[pat_len] = b.char_byte;
					pat_len++;
				end else begin
					pat_ovf = 1'b1;
				end
				if (b.last) begin
					pat_done = 1'b1;
				end
				clear_walk();
			end else begin
				match_symbol({1'b0, b.char_byte}, b.last);
				if (b.last) begin
					match_symbol(SYM_END, 1'b0);
					v.matched = v_match;
					v.status  = v_status;
					verdicts_due.insert(verdicts_due.size(), v);
					clear_walk();
				end
			end
		endfunction

		// Compare an accepted result beat with the oldest pending verdict
		function void check_result(mqtf_pkg::out_item_t r);
			mqtf_pkg::out_item_t v;
			if (verdicts_due.size() == 0) begin
				$error("result beat with no verdict pending: matched %0b status %0b",
					r.matched, r.status);
				errors++;
				return;
			end
			v = verdicts_due.pop_front();
			if (r.matched !== v.matched) begin
				$error("matched: expected %0b, got %0b", v.matched, r.matched);
				errors++;
			end
			if (r.status !== v.status) begin
				$error("status: expected %0b, got %0b", v.status, r.status);
				errors++;
			end
		endfunction
	endclass

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_stall;
	mqtf_pkg::in_item_t  item         = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	mqtf_pkg::out_item_t result;

	verdict_board board;
	logic [7:0]   flt_q[$];
	logic [7:0]   top_q[$];
	int           snd_idle   = 17;
	int           rcv_idle   = 55;
	bit           hold_req   = 1'b0;
	int           hold_left  = 0;
	int           beats_sent = 0;
	int           quiet      = 0;

	mqtt_topic_filter_match_top #(.FILTER_DEPTH(DEPTH)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always #5 clk = ~clk;

	// Offer one beat, idling at random first, and hold it until accepted
	task automatic send_beat(logic f, logic [7:0] c, logic l);
		mqtf_pkg::in_item_t b;
		b.func      = f;
		b.char_byte = c;
		b.last      = l;
		while ($urandom_range(0, 99) < snd_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= b;
		do @(posedge clk); while (item_stall);
		board.note_item(b);
		beats_sent++;
	endtask

	task automatic send_filter(bit done);
		for (int i = 0; i < flt_q.size(); i++) begin
			send_beat(1'b0, flt_q[i], done && (i == flt_q.size() - 1));
		end
	endtask

	// A cut topic never gets its last mark; the next filter beat drops it
	task automatic send_topic(bit cut);
		for (int i = 0; i < top_q.size(); i++) begin
			send_beat(1'b1, top_q[i], !cut && (i == top_q.size() - 1));
		end
	endtask

	// Append one byte to the filter or the topic being built
	function automatic void add_flt(logic [7:0] c);
		flt_q.insert(flt_q.size(), c);
	endfunction

	function automatic void add_top(logic [7:0] c);
		top_q.insert(top_q.size(), c);
	endfunction

	function automatic void set_filter(string s);
		flt_q.delete();
		for (int i = 0; i < s.len(); i++) begin
			add_flt(s[i]);
		end
	endfunction

	function automatic void set_topic(string s);
		top_q.delete();
		for (int i = 0; i < s.len(); i++) begin
			add_top(s[i]);
		end
	endfunction

	// Mostly 'a'..'c' so levels collide often; now and then any byte
	function automatic logic [7:0] word_char();
		if ($urandom_range(0, 15) == 0) begin
			return 8'($urandom_range(0, 255));
		end
		return 8'h61 + 8'($urandom_range(0, 2));
	endfunction

	function automatic logic [7:0] odd_char();
		case ($urandom_range(0, 5))
			0: return mqtf_pkg::CH_PLUS;
			1: return mqtf_pkg::CH_HASH;
			2: return mqtf_pkg::CH_SLASH;
			3: return mqtf_pkg::CH_DOLLAR;
			4: return 8'h61;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Levels of words and wildcards, sometimes with a leading dollar or a misplaced wildcard
	function automatic void make_filter();
		int nlev;
		int pick;
		nlev = $urandom_range(1, 4);
		flt_q.delete();
		if ($urandom_range(0, 7) == 0) begin
			add_flt(mqtf_pkg::CH_DOLLAR);
		end
		for (int i = 0; i < nlev; i++) begin
			if (i > 0) begin
				add_flt(mqtf_pkg::CH_SLASH);
			end
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				add_flt(mqtf_pkg::CH_PLUS);
			end else if (pick < 5 && i == nlev - 1) begin
				add_flt(mqtf_pkg::CH_HASH);
			end else begin
				repeat ($urandom_range(1, 2)) add_flt(word_char());
			end
		end
		if ($urandom_range(0, 9) == 0) begin
			flt_q[$urandom_range(0, flt_q.size() - 1)] =
				($urandom_range(0, 1) != 0) ? mqtf_pkg::CH_PLUS : mqtf_pkg::CH_HASH;
		end
	endfunction

	// Topic that fits the current filter, then mutated now and then
	function automatic void make_topic();
		int nlev;
		top_q.delete();
		foreach (flt_q[j]) begin
			if (flt_q[j] == mqtf_pkg::CH_PLUS) begin
				repeat ($urandom_range(1, 2)) add_top(word_char());
			end else if (flt_q[j] == mqtf_pkg::CH_HASH) begin
				nlev = $urandom_range(0, 2);
				if (nlev == 0 && top_q.size() > 0 &&
						top_q[top_q.size() - 1] == mqtf_pkg::CH_SLASH) begin
					// parent level: drop the separator too
					void'(top_q.pop_back());
				end else begin
					add_top(word_char());
					for (int k = 1; k < nlev; k++) begin
						add_top(mqtf_pkg::CH_SLASH);
						add_top(word_char());
					end
				end
			end else begin
				add_top(flt_q[j]);
			end
		end
		if (top_q.size() == 0) begin
			add_top(word_char());
		end
		if ($urandom_range(0, 3) == 0) begin
			top_q[$urandom_range(0, top_q.size() - 1)] = odd_char();
		end
		if ($urandom_range(0, 9) == 0) begin
			add_top(mqtf_pkg::CH_SLASH);
			add_top(word_char());
		end
		if ($urandom_range(0, 9) == 0 && top_q.size() > 1) begin
			void'(top_q.pop_back());
		end
	endfunction

	function automatic void noise_bytes(bit to_filter, int n);
		for (int i = 0; i < n; i++) begin
			if (to_filter) begin
				add_flt(8'($urandom_range(0, 255)));
			end else begin
				add_top(8'($urandom_range(0, 255)));
			end
		end
	endfunction

	// Result side: check accepted beats, stall at random or for one long hold
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				board.check_result(result);
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < rcv_idle);
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int round;
		int phase;
		round = 0;
		phase = 0;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty filter, then a lone plus
		set_topic("a");
		send_topic(1'b0);
		set_filter("+");
		send_filter(1'b1);
		set_topic("x");
		send_topic(1'b0);
		// lone hash against a dollar topic
		set_filter("#");
		send_filter(1'b1);
		set_topic("$s");
		send_topic(1'b0);
		// unfinished filter, then the parent level of a hash
		set_filter("a/");
		send_filter(1'b0);
		set_topic("a");
		send_topic(1'b0);
		set_filter("#");
		send_filter(1'b1);
		set_topic("a");
		send_topic(1'b0);
		// filter beat in the middle of a topic
		set_topic("a/");
		send_topic(1'b1);
		set_filter("b");
		send_filter(1'b1);
		set_topic("b");
		send_topic(1'b0);
		// wildcard inside the topic
		set_filter("+/#");
		send_filter(1'b1);
		set_topic("#");
		send_topic(1'b0);
		// extreme byte values, zero included
		top_q.delete();
		add_top(8'h00);
		add_top(8'hFF);
		add_top(8'h01);
		send_topic(1'b0);

		// random: mostly well-formed filters with fitting topics, some noise
		while (beats_sent < N_BEATS) begin
			round++;
			if (phase == 0 && beats_sent >= N_BEATS / 3) begin
				snd_idle = 55;
				rcv_idle = 17;
				phase    = 1;
			end
			if (phase == 1 && beats_sent >= 2 * N_BEATS / 3) begin
				snd_idle = 0;
				rcv_idle = 0;
				hold_req = 1'b1;
				phase    = 2;
			end
			flt_q.delete();
			if (round % 40 == 0) begin
				// overlong filter
				repeat (DEPTH + $urandom_range(1, 4)) add_flt(word_char());
			end else if ($urandom_range(0, 99) < 8) begin
				noise_bytes(1'b1, $urandom_range(1, 8));
			end else begin
				make_filter();
			end
			send_filter($urandom_range(0, 19) != 0);
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 99) < 8) begin
					top_q.delete();
					noise_bytes(1'b0, $urandom_range(1, 8));
				end else begin
					make_topic();
				end
				send_topic($urandom_range(0, 19) == 0);
			end
		end
		item_valid <= 1'b0;

		// drain the pending verdicts, then watch for strays
		while (board.verdicts_due.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (board.errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
